[design/rsnh_pkg.sv]
// Shared types, codes and helper functions of the ray scene nearest-hit block.
package rsnh_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RAY  = 1'b1;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic              operation;
		logic [3:0]        entry_index;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [30:0]       sphere_radius;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} item_t;

	typedef struct packed {
		logic              hit;
		logic              hit_kind;
		logic [3:0]        hit_sphere;
		logic [30:0]       hit_distance;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic              checker_parity;
	} result_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [30:0]       r;
	} sph_ent_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD,
		ST_LC,
		ST_TCA,
		ST_D2,
		ST_SQ1,
		ST_T,
		ST_HP,
		ST_V,
		ST_VV,
		ST_SQ2,
		ST_DSTART,
		ST_DIV,
		ST_NEXT,
		ST_PLANE,
		ST_PDIV,
		ST_PT,
		ST_PCHK,
		ST_OUT
	} state_t;

	function automatic logic signed [63:0] sx64(input logic signed [31:0] a);
		return $signed({{32{a[31]}}, a});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > sx64(S32_MAX)) begin
			r = S32_MAX;
		end else if (v < sx64(S32_MIN)) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[design/rsnh_sqrt.sv]
// Iterative square root, one result bit per cycle, of a fixed-point value.
module rsnh_sqrt #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [63:0] x,
	output logic              done,
	output logic [31:0]       root
);
	localparam logic [63:0] CAP = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;

	logic [63:0] rad_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [63:0] u;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        ge;

	always_comb begin
		if (x <= 64'sd0) begin
			u = '0;
		end else if ($unsigned(x) > CAP) begin
			u = CAP;
		end else begin
			u = $unsigned(x);
		end
		rem_sh = {rem_q[33:0], rad_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd31;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= u << FRAC_BITS;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[design/rsnh_div.sv]
// Iterative restoring divider with a 32-bit signed, saturated quotient.
module rsnh_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       num,
	input  logic [31:0]       den,
	input  logic              neg,
	output logic              done,
	output logic signed [31:0] quot
);
	import rsnh_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] sh_q;
	logic [31:0] q_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic        ovf_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic        ovf;
	logic [32:0] rem2;
	logic [32:0] diff;
	logic        ge;

	always_comb begin
		ovf  = num >= {den, 32'h0};
		rem2 = {rem_q, sh_q[31]};
		diff = rem2 - {1'b0, den_q};
		ge   = rem2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// A quotient that cannot fit is known at once.
				run_q  <= !ovf;
				done_q <= ovf;
				cnt_q  <= 5'd31;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[63:32];
			sh_q  <= num[31:0];
			q_q   <= '0;
			den_q <= den;
			neg_q <= neg;
			ovf_q <= ovf;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : rem2[31:0];
			sh_q  <= sh_q << 1;
			q_q   <= {q_q[30:0], ge};
		end
	end

	always_comb begin
		if (ovf_q || q_q[31]) begin
			quot = neg_q ? S32_MIN : S32_MAX;
		end else begin
			quot = neg_q ? -$signed(q_q) : $signed(q_q);
		end
	end

	assign done = done_q;

endmodule

[design/ray_scene_nearest_hit.sv]
// Ray against sphere table and bounded checker plane, nearest-hit search, top level.
// A load transaction writes its table entry at the edge that accepts it.
// A ray tests each sphere in turn; a sphere whose roots are taken and that becomes the nearest
// so far adds the hit point, a square root and, if that root is not zero, three divisions;
// then come the plane test and the output step.
// One ray at a time; reset clears the control state and the sphere count, not the sphere table.
module ray_scene_nearest_hit #(
	parameter int MAX_SPHERES = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  rsnh_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_stall,
	output rsnh_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [4:0]       cfg_data
);
	import rsnh_pkg::*;

	localparam int KW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int CW = $clog2(MAX_SPHERES + 1);

	localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
	localparam logic [63:0]        THR     = (64'd1 << FRAC_BITS) / 64'd1000;
	localparam logic signed [63:0] LIM_HIT = 64'sd1000 * ONE;
	localparam logic signed [63:0] X_LIM   = 64'sd10 * ONE;
	localparam logic signed [63:0] Z_NEAR  = -64'sd10 * ONE;
	localparam logic signed [63:0] Z_FAR   = -64'sd30 * ONE;
	localparam logic signed [63:0] PL_OFF  = 64'sd4 * ONE;
	localparam logic signed [63:0] PAR_OFF = 64'sd2000 * ONE;

	// Control state.
	state_t          state_q, nxt;
	logic [2:0]      stp_q;
	logic [CW-1:0]   k_q;
	logic [1:0]      dc_q;
	logic [4:0]      count_q;
	logic            found_q;
	logic            plane_q;
	logic            res_valid_q;

	// Datapath registers.
	logic signed [31:0] o_q [3];
	logic signed [31:0] d_q [3];
	logic signed [31:0] c_q [3];
	logic signed [31:0] l_q [3];
	logic signed [31:0] hp_q [3];
	logic signed [31:0] v_q [3];
	logic signed [31:0] nv_q [3];
	logic signed [31:0] pt_q [3];
	logic [30:0]        r_q;
	logic signed [31:0] tca_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] t_q;
	logic signed [31:0] pd_q;
	logic [30:0]        best_q;
	logic [KW-1:0]      bk_q;
	logic               par_q;
	result_t            res_q;

	// The sphere table: one synchronous memory, read data registered.
	sph_ent_t stab_q [MAX_SPHERES];
	sph_ent_t rdat_q;

	// Shared arithmetic units and their operands.
	logic signed [31:0] mul_a, mul_b;
	logic               sq_start, sq_done;
	logic signed [63:0] sq_x;
	logic [31:0]        sq_root;
	logic               dv_start, dv_done, dv_neg;
	logic [63:0]        dv_num;
	logic [31:0]        dv_den;
	logic signed [31:0] dv_quot;

	// Combinational helpers.
	logic signed [63:0] term;
	logic [8:0]         cnt9, n9;
	logic [CW-1:0]      n_eff, k_inc;
	logic [KW+3:0]      widx, bk_ext;
	logic               idx_ok, ray_acc, load_acc, out_free;
	logic               miss;
	logic signed [33:0] t1, t2, tsel;
	logic [30:0]        tsat;
	logic               better;
	logic signed [31:0] o_sel, v_sel;
	logic signed [31:0] hp_new;
	logic [31:0]        ay;
	logic               ay_ok;
	logic signed [63:0] pnum, pmag, vmag;
	logic signed [63:0] ps0, ps2;
	logic               pwin;

	rsnh_sqrt #(
		.FRAC_BITS(FRAC_BITS)
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.x     (sq_x),
		.done  (sq_done),
		.root  (sq_root)
	);

	rsnh_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dv_start),
		.num   (dv_num),
		.den   (dv_den),
		.neg   (dv_neg),
		.done  (dv_done),
		.quot  (dv_quot)
	);

	// Decode of the incoming transaction and of the sphere count.
	always_comb begin
		widx     = {{KW{1'b0}}, item.entry_index};
		idx_ok   = widx < (KW + 4)'(MAX_SPHERES);
		load_acc = (state_q == ST_IDLE) && item_valid && (item.operation == OP_LOAD);
		ray_acc  = (state_q == ST_IDLE) && item_valid && (item.operation == OP_RAY);
		cnt9     = {4'b0, count_q};
		n9       = (cnt9 > 9'(MAX_SPHERES)) ? 9'(MAX_SPHERES) : cnt9;
		n_eff    = n9[CW-1:0];
		k_inc    = k_q + CW'(1);
		out_free = !res_valid_q || !result_stall;
		term     = prod_q >>> FRAC_BITS;
	end

	// Sphere and plane arithmetic that the sequencer tests against.
	always_comb begin
		// The sphere is missed when d2 exceeds r2; term holds r2 at the last step.
		miss = acc_q > term;

		// Near root first, the far root if the near one lies behind the origin.
		t1   = 34'(tca_q) - $signed({2'b00, sq_root});
		t2   = 34'(tca_q) + $signed({2'b00, sq_root});
		tsel = t1[33] ? t2 : t1;
		tsat = (tsel > 34'sd2147483647) ? 31'h7FFF_FFFF : tsel[30:0];
		better = !tsel[33] && (!found_q || (tsat < best_q));

		case (stp_q)
			3'd1:    o_sel = o_q[0];
			3'd2:    o_sel = o_q[1];
			default: o_sel = o_q[2];
		endcase
		hp_new = sat32(sx64(o_sel) + term);

		case (dc_q)
			2'd0:    v_sel = v_q[0];
			2'd1:    v_sel = v_q[1];
			default: v_sel = v_q[2];
		endcase
		vmag = v_sel[31] ? -sx64(v_sel) : sx64(v_sel);

		ay    = d_q[1][31] ? (~d_q[1] + 32'd1) : d_q[1];
		ay_ok = {32'b0, ay} > THR;
		pnum  = -(sx64(o_q[1]) + PL_OFF);
		pmag  = pnum[63] ? -pnum : pnum;

		// The plane is bounded in x and z, and only a strictly nearer hit replaces a sphere.
		pwin = (pd_q > 32'sd0) &&
			(sx64(pt_q[0]) < X_LIM) && (sx64(pt_q[0]) > -X_LIM) &&
			(sx64(pt_q[2]) < Z_NEAR) && (sx64(pt_q[2]) > Z_FAR) &&
			(!found_q || (pd_q[30:0] < best_q));
		// Checker parity: bit one above the fraction of each truncated half coordinate.
		ps0 = sx64(pt_q[0]) + PAR_OFF;
		ps2 = -sx64(pt_q[2]);
	end

	// Next-state logic of the sequencer.
	always_comb begin
		nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ray_acc) begin
					nxt = (n_eff == '0) ? ST_PLANE : ST_RD;
				end
			end
			ST_RD:  nxt = ST_LC;
			ST_LC:  nxt = ST_TCA;
			ST_TCA: begin
				if (stp_q == 3'd3) begin
					nxt = ST_D2;
				end
			end
			ST_D2: begin
				if (stp_q == 3'd5) begin
					nxt = miss ? ST_NEXT : ST_SQ1;
				end
			end
			ST_SQ1: begin
				if (sq_done) begin
					nxt = ST_T;
				end
			end
			ST_T:   nxt = better ? ST_HP : ST_NEXT;
			ST_HP: begin
				if (stp_q == 3'd3) begin
					nxt = ST_V;
				end
			end
			ST_V:   nxt = ST_VV;
			ST_VV: begin
				if (stp_q == 3'd3) begin
					nxt = ST_SQ2;
				end
			end
			ST_SQ2: begin
				if (sq_done) begin
					nxt = (sq_root == 32'd0) ? ST_NEXT : ST_DSTART;
				end
			end
			ST_DSTART: nxt = ST_DIV;
			ST_DIV: begin
				if (dv_done) begin
					nxt = (dc_q == 2'd2) ? ST_NEXT : ST_DSTART;
				end
			end
			ST_NEXT: nxt = (k_inc == n_eff) ? ST_PLANE : ST_RD;
			ST_PLANE: nxt = ay_ok ? ST_PDIV : ST_OUT;
			ST_PDIV: begin
				if (dv_done) begin
					nxt = ST_PT;
				end
			end
			ST_PT: begin
				if (stp_q == 3'd3) begin
					nxt = ST_PCHK;
				end
			end
			ST_PCHK: nxt = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					nxt = ST_IDLE;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs: operand selection and unit starts.
	always_comb begin
		item_stall = (state_q != ST_IDLE);
		mul_a      = '0;
		mul_b      = '0;
		sq_start   = 1'b0;
		sq_x       = acc_q + term;
		dv_start   = 1'b0;
		dv_num     = vmag << FRAC_BITS;
		dv_den     = sq_root;
		dv_neg     = v_sel[31];
		case (state_q)
			ST_TCA: begin
				case (stp_q)
					3'd0: begin mul_a = l_q[0]; mul_b = d_q[0]; end
					3'd1: begin mul_a = l_q[1]; mul_b = d_q[1]; end
					3'd2: begin mul_a = l_q[2]; mul_b = d_q[2]; end
					default: ;
				endcase
			end
			ST_D2: begin
				case (stp_q)
					3'd0: begin mul_a = l_q[0]; mul_b = l_q[0]; end
					3'd1: begin mul_a = l_q[1]; mul_b = l_q[1]; end
					3'd2: begin mul_a = l_q[2]; mul_b = l_q[2]; end
					3'd3: begin mul_a = tca_q; mul_b = tca_q; end
					3'd4: begin
						mul_a = $signed({1'b0, r_q});
						mul_b = $signed({1'b0, r_q});
					end
					default: ;
				endcase
				sq_x     = term - acc_q;
				sq_start = (stp_q == 3'd5) && !miss;
			end
			ST_HP: begin
				mul_b = t_q;
				case (stp_q)
					3'd0:    mul_a = d_q[0];
					3'd1:    mul_a = d_q[1];
					3'd2:    mul_a = d_q[2];
					default: mul_b = '0;
				endcase
			end
			ST_VV: begin
				case (stp_q)
					3'd0: begin mul_a = v_q[0]; mul_b = v_q[0]; end
					3'd1: begin mul_a = v_q[1]; mul_b = v_q[1]; end
					3'd2: begin mul_a = v_q[2]; mul_b = v_q[2]; end
					default: ;
				endcase
				sq_start = (stp_q == 3'd3);
			end
			ST_DSTART: dv_start = 1'b1;
			ST_PLANE: begin
				dv_start = ay_ok;
				dv_num   = pmag << FRAC_BITS;
				dv_den   = ay;
				dv_neg   = pnum[63] ^ d_q[1][31];
			end
			ST_PT: begin
				mul_b = pd_q;
				case (stp_q)
					3'd0:    mul_a = d_q[0];
					3'd1:    mul_a = d_q[1];
					3'd2:    mul_a = d_q[2];
					default: mul_b = '0;
				endcase
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stp_q       <= '0;
			k_q         <= '0;
			dc_q        <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			plane_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			stp_q   <= (nxt != state_q) ? 3'd0 : (stp_q + 3'd1);
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (ray_acc) begin
				k_q     <= '0;
				found_q <= 1'b0;
				plane_q <= 1'b0;
			end
			if (state_q == ST_NEXT) begin
				k_q <= k_inc;
			end
			if (state_q == ST_T && better) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_SQ2) begin
				dc_q <= '0;
			end
			if (state_q == ST_DIV && dv_done) begin
				dc_q <= dc_q + 2'd1;
			end
			if (state_q == ST_PCHK && pwin) begin
				found_q <= 1'b1;
				plane_q <= 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Table write on a load transaction, table read at the current sphere every cycle.
	always_ff @(posedge clk) begin
		if (load_acc && idx_ok) begin
			stab_q[widx[KW-1:0]] <= '{cx: item.center_x, cy: item.center_y,
				cz: item.center_z, r: item.sphere_radius};
		end
		rdat_q <= stab_q[k_q[KW-1:0]];
	end

	always_ff @(posedge clk) begin
		prod_q <= sx64(mul_a) * sx64(mul_b);
		case (state_q)
			ST_IDLE: begin
				if (ray_acc) begin
					o_q[0] <= item.origin_x;
					o_q[1] <= item.origin_y;
					o_q[2] <= item.origin_z;
					d_q[0] <= item.dir_x;
					d_q[1] <= item.dir_y;
					d_q[2] <= item.dir_z;
					best_q <= '0;
					bk_q   <= '0;
					par_q  <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						hp_q[i] <= '0;
						nv_q[i] <= '0;
					end
				end
			end
			ST_LC: begin
				c_q[0] <= rdat_q.cx;
				c_q[1] <= rdat_q.cy;
				c_q[2] <= rdat_q.cz;
				r_q    <= rdat_q.r;
				l_q[0] <= sat32(sx64(rdat_q.cx) - sx64(o_q[0]));
				l_q[1] <= sat32(sx64(rdat_q.cy) - sx64(o_q[1]));
				l_q[2] <= sat32(sx64(rdat_q.cz) - sx64(o_q[2]));
			end
			ST_TCA, ST_VV: begin
				if (stp_q == 3'd1) begin
					acc_q <= term;
				end else if (stp_q != 3'd0) begin
					acc_q <= acc_q + term;
				end
				if (state_q == ST_TCA && stp_q == 3'd3) begin
					tca_q <= sat32(acc_q + term);
				end
			end
			ST_D2: begin
				case (stp_q)
					3'd1:       acc_q <= term;
					3'd2, 3'd3: acc_q <= acc_q + term;
					3'd4:       acc_q <= acc_q - term;
					default: ;
				endcase
			end
			ST_T: begin
				if (better) begin
					best_q <= tsat;
					t_q    <= $signed({1'b0, tsat});
					bk_q   <= k_q[KW-1:0];
				end
			end
			ST_HP: begin
				case (stp_q)
					3'd1: hp_q[0] <= hp_new;
					3'd2: hp_q[1] <= hp_new;
					3'd3: hp_q[2] <= hp_new;
					default: ;
				endcase
			end
			ST_V: begin
				for (int i = 0; i < 3; i++) begin
					v_q[i] <= sat32(sx64(hp_q[i]) - sx64(c_q[i]));
				end
			end
			ST_SQ2: begin
				if (sq_done && sq_root == 32'd0) begin
					for (int i = 0; i < 3; i++) begin
						nv_q[i] <= '0;
					end
				end
			end
			ST_DIV: begin
				if (dv_done) begin
					case (dc_q)
						2'd0:    nv_q[0] <= dv_quot;
						2'd1:    nv_q[1] <= dv_quot;
						default: nv_q[2] <= dv_quot;
					endcase
				end
			end
			ST_PDIV: begin
				if (dv_done) begin
					pd_q <= dv_quot;
				end
			end
			ST_PT: begin
				case (stp_q)
					3'd1: pt_q[0] <= hp_new;
					3'd2: pt_q[1] <= hp_new;
					3'd3: pt_q[2] <= hp_new;
					default: ;
				endcase
			end
			ST_PCHK: begin
				if (pwin) begin
					best_q  <= pd_q[30:0];
					bk_q    <= '0;
					hp_q[0] <= pt_q[0];
					hp_q[1] <= pt_q[1];
					hp_q[2] <= pt_q[2];
					nv_q[0] <= '0;
					nv_q[1] <= ONE[31:0];
					nv_q[2] <= '0;
					par_q   <= ps0[FRAC_BITS+1] ^ ps2[FRAC_BITS+1];
				end
			end
			ST_OUT: begin
				if (out_free) begin
					if (found_q) begin
						res_q.hit            <= $signed({33'b0, best_q}) < LIM_HIT;
						res_q.hit_kind       <= plane_q;
						res_q.hit_sphere     <= bk_ext[3:0];
						res_q.hit_distance   <= best_q;
						res_q.hit_x          <= hp_q[0];
						res_q.hit_y          <= hp_q[1];
						res_q.hit_z          <= hp_q[2];
						res_q.normal_x       <= nv_q[0];
						res_q.normal_y       <= nv_q[1];
						res_q.normal_z       <= nv_q[2];
						res_q.checker_parity <= par_q;
					end else begin
						res_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign bk_ext       = {4'b0, bk_q};
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

[design/rsnh_checker.sv]
// Port-level checks of the ray scene nearest-hit block and their binding.
module rsnh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input rsnh_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input rsnh_pkg::result_t result
);
	import rsnh_pkg::*;

	// A result held back by the sink stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or was withdrawn");

	// A load transaction produces no result and leaves the block ready.
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.operation == OP_LOAD |=> !item_stall)
		else $error("block busy after a load transaction");

	// A ray transaction keeps the block busy while it is being worked on.
	a_ray_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.operation == OP_RAY |=> item_stall)
		else $error("block took a new transaction straight after a ray");

	// A plane hit reports no sphere and a normal along y.
	a_plane_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit_kind |->
			result.hit_sphere == 4'd0 && result.normal_x == 32'sd0 &&
			result.normal_z == 32'sd0)
		else $error("plane hit with inconsistent fields");

endmodule

bind ray_scene_nearest_hit rsnh_checker u_rsnh_checker (.*);
